@@ design/bitonic_array_search_core_defines.svh @@
// Assertion macros for the bitonic array search core.
// Sampled on clk, disabled while rst_n is low; no other dependencies.
`ifndef BITONIC_ARRAY_SEARCH_CORE_DEFINES_SVH
`define BITONIC_ARRAY_SEARCH_CORE_DEFINES_SVH

// Implication in the same cycle.
`define BAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle.
`define BAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/bas_pkg.sv @@
// Package for the bitonic array search core: sizes, microcode step codes,
// control word layout and the microcode ROM. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bas_pkg;

  localparam int MAX_LENGTH = 1024;
  localparam int IDX_W      = $clog2(MAX_LENGTH);
  localparam int LEN_W      = 11;
  localparam int DATA_W     = 32;
  localparam int PTR_W      = IDX_W + 2;

  typedef enum logic [4:0] {
    S_IDLE, S_ENTRY,
    P_TOP, P_CHK2, P_ONE, P_MID, P_RB, P_RC, P_DEC,
    P_TWO, P_TWO_B, P_TWO_C,
    R_INIT, R_TOP, R_CMP,
    F_INIT, F_TOP, F_CMP,
    S_MISS, S_EMIT
  } step_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_ACCEPT, OP_SET_MID, OP_LD_A, OP_LD_B, OP_PK_UPD,
    OP_PEAK_LO, OP_PEAK_TWO, OP_RISE_INIT, OP_RISE_UPD,
    OP_FALL_INIT, OP_FALL_UPD, OP_MISS, OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    A_MID, A_MIDC, A_MIDC_M1, A_MID_P1, A_LO, A_HI
  } asel_t;

  typedef enum logic [3:0] {
    C_ALWAYS, C_SEARCH, C_NZERO, C_LO_EQ_HI, C_ADJ, C_FLAT,
    C_LO_GT_HI, C_HIT, C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    asel_t asel;
    cond_t cond;
    step_t jt;
    step_t jf;
  } ctrl_t;

  function automatic ctrl_t word(op_t op, asel_t asel, cond_t cond, step_t jt, step_t jf);
    ctrl_t w;
    w.op   = op;
    w.asel = asel;
    w.cond = cond;
    w.jt   = jt;
    w.jf   = jf;
    return w;
  endfunction

  // Microcode ROM: jump to jt when the condition holds, else to jf.
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    case (s)
      S_IDLE:  w = word(OP_ACCEPT,    A_MID,     C_SEARCH,   S_ENTRY, S_IDLE);
      S_ENTRY: w = word(OP_NOP,       A_MID,     C_NZERO,    P_TOP,   S_MISS);
      P_TOP:   w = word(OP_NOP,       A_MID,     C_LO_EQ_HI, P_ONE,   P_CHK2);
      P_CHK2:  w = word(OP_NOP,       A_LO,      C_ADJ,      P_TWO,   P_MID);
      P_ONE:   w = word(OP_PEAK_LO,   A_MID,     C_ALWAYS,   R_INIT,  R_INIT);
      P_MID:   w = word(OP_SET_MID,   A_MIDC_M1, C_ALWAYS,   P_RB,    P_RB);
      P_RB:    w = word(OP_LD_A,      A_MID,     C_ALWAYS,   P_RC,    P_RC);
      P_RC:    w = word(OP_LD_B,      A_MID_P1,  C_ALWAYS,   P_DEC,   P_DEC);
      P_DEC:   w = word(OP_PK_UPD,    A_MID,     C_FLAT,     R_INIT,  P_TOP);
      P_TWO:   w = word(OP_NOP,       A_LO,      C_ALWAYS,   P_TWO_B, P_TWO_B);
      P_TWO_B: w = word(OP_LD_A,      A_HI,      C_ALWAYS,   P_TWO_C, P_TWO_C);
      P_TWO_C: w = word(OP_PEAK_TWO,  A_MID,     C_ALWAYS,   R_INIT,  R_INIT);
      R_INIT:  w = word(OP_RISE_INIT, A_MID,     C_ALWAYS,   R_TOP,   R_TOP);
      R_TOP:   w = word(OP_SET_MID,   A_MIDC,    C_LO_GT_HI, F_INIT,  R_CMP);
      R_CMP:   w = word(OP_RISE_UPD,  A_MID,     C_HIT,      S_EMIT,  R_TOP);
      F_INIT:  w = word(OP_FALL_INIT, A_MID,     C_ALWAYS,   F_TOP,   F_TOP);
      F_TOP:   w = word(OP_SET_MID,   A_MIDC,    C_LO_GT_HI, S_MISS,  F_CMP);
      F_CMP:   w = word(OP_FALL_UPD,  A_MID,     C_HIT,      S_EMIT,  F_TOP);
      S_MISS:  w = word(OP_MISS,      A_MID,     C_ALWAYS,   S_EMIT,  S_EMIT);
      S_EMIT:  w = word(OP_EMIT,      A_MID,     C_OUT_FREE, S_IDLE,  S_EMIT);
      default: w = word(OP_NOP,       A_MID,     C_ALWAYS,   S_IDLE,  S_IDLE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ design/bitonic_array_search_core.sv @@
// Bitonic array search core: element memory, microcoded sequencer and datapath.
// Depends on bas_pkg and bitonic_array_search_core_defines.svh.
//
// Usage:
//   in_* carries load and search transactions. in_tuser[0] is the action
//   (0 load, 1 search). A load writes in_tdata element at in_tdata index and
//   leaves the core idle. A search runs up to three binary searches over the
//   loaded elements: peak location, rising part, then falling part on a miss.
//   out_* carries one result per search: found and position.
//   cfg_wr_en / cfg_wr_data set the array length (values above 1024 saturate).
//   Write it only while the core is idle.
// Timing:
//   Each peak probe reads three neighbouring elements and each side search probe
//   reads one, all through the single registered read port, which sets the cost;
//   an empty array goes straight from entry to the miss result.
//   The core accepts the next transaction while a result waits in the output
//   register; a search that finishes before out_tready stalls in its last
//   step until the output register frees.
// Reset:
//   Synchronous, rst_n low. Length returns to 1, no result is pending.
//   The element memory is not cleared; read only entries that were loaded.
`timescale 1ns / 1ps
`default_nettype none
`include "bitonic_array_search_core_defines.svh"

module bitonic_array_search_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,  // index[9:0], element[41:10], search_key[73:42], zeros
  input  wire logic [0:0]  in_tuser,  // action[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata, // found[0], position[10:1], zeros
  input  wire logic        cfg_wr_en,
  input  wire logic [10:0] cfg_wr_data
);

  localparam int IW = bas_pkg::IDX_W;
  localparam int PW = bas_pkg::PTR_W;
  localparam int DW = bas_pkg::DATA_W;
  localparam int LW = bas_pkg::LEN_W;

  logic signed [DW-1:0] mem [bas_pkg::MAX_LENGTH];
  logic signed [DW-1:0] rd_r;

  bas_pkg::step_t step_r, step_nxt;
  bas_pkg::ctrl_t ctrl;

  logic [LW-1:0]        len_r;
  logic [LW-1:0]        n_r, n_nxt;
  logic signed [DW-1:0] key_r, key_nxt;
  logic signed [PW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, peak_r, peak_nxt;
  logic signed [DW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic                 found_r, found_nxt;
  logic [IW-1:0]        pos_r, pos_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [IW-1:0]        out_pos_r, out_pos_nxt;

  logic                 in_acc;
  logic                 is_search;
  logic [IW-1:0]        in_index;
  logic signed [DW-1:0] in_element, in_key;
  logic [LW-1:0]        n_sat;
  logic signed [PW-1:0] midc, raddr, n_m1;
  logic                 rising, falling, cond_ok, out_free;

  assign in_index   = in_tdata[IW-1:0];
  assign in_element = $signed(in_tdata[IW+DW-1:IW]);
  assign in_key     = $signed(in_tdata[IW+2*DW-1:IW+DW]);
  assign is_search  = in_tuser[0];

  assign in_tready = (step_r == bas_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign n_sat = (len_r > LW'(bas_pkg::MAX_LENGTH)) ? LW'(bas_pkg::MAX_LENGTH) : len_r;
  assign n_m1  = $signed({1'b0, n_r}) - PW'(1);
  assign midc  = lo_r + ((hi_r - lo_r) >>> 1);

  assign rising  = (a_r < b_r) && (b_r < rd_r);
  assign falling = (a_r > b_r) && (b_r > rd_r);

  assign ctrl = bas_pkg::ucode(step_r);

  always_comb begin
    case (ctrl.asel)
      bas_pkg::A_MIDC:    raddr = midc;
      bas_pkg::A_MIDC_M1: raddr = midc - PW'(1);
      bas_pkg::A_MID_P1:  raddr = mid_r + PW'(1);
      bas_pkg::A_LO:      raddr = lo_r;
      bas_pkg::A_HI:      raddr = hi_r;
      default:            raddr = mid_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && !is_search) begin
      mem[in_index] <= in_element;
    end
    rd_r <= mem[raddr[IW-1:0]];
  end

  always_comb begin
    case (ctrl.cond)
      bas_pkg::C_SEARCH:   cond_ok = in_acc && is_search;
      bas_pkg::C_NZERO:    cond_ok = (n_r != '0);
      bas_pkg::C_LO_EQ_HI: cond_ok = (lo_r == hi_r);
      bas_pkg::C_ADJ:      cond_ok = (hi_r == lo_r + PW'(1));
      bas_pkg::C_FLAT:     cond_ok = !rising && !falling;
      bas_pkg::C_LO_GT_HI: cond_ok = (lo_r > hi_r);
      bas_pkg::C_HIT:      cond_ok = (rd_r == key_r);
      bas_pkg::C_OUT_FREE: cond_ok = out_free;
      default:             cond_ok = 1'b1;
    endcase
  end

  always_comb begin
    step_nxt      = cond_ok ? ctrl.jt : ctrl.jf;
    n_nxt         = n_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    peak_nxt      = peak_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    case (ctrl.op)
      bas_pkg::OP_ACCEPT: begin
        if (in_acc && is_search) begin
          key_nxt = in_key;
          n_nxt   = n_sat;
          lo_nxt  = '0;
          hi_nxt  = $signed({1'b0, n_sat}) - PW'(1);
        end
      end
      bas_pkg::OP_SET_MID:  mid_nxt = midc;
      bas_pkg::OP_LD_A:     a_nxt = rd_r;
      bas_pkg::OP_LD_B:     b_nxt = rd_r;
      bas_pkg::OP_PK_UPD: begin
        if (rising) begin
          lo_nxt = mid_r + PW'(1);
        end else if (falling) begin
          hi_nxt = mid_r - PW'(1);
        end else begin
          peak_nxt = mid_r;
        end
      end
      bas_pkg::OP_PEAK_LO:  peak_nxt = lo_r;
      bas_pkg::OP_PEAK_TWO: peak_nxt = (a_r >= rd_r) ? lo_r : hi_r;
      bas_pkg::OP_RISE_INIT: begin
        lo_nxt = '0;
        hi_nxt = peak_r;
      end
      bas_pkg::OP_RISE_UPD: begin
        if (rd_r == key_r) begin
          found_nxt = 1'b1;
          pos_nxt   = mid_r[IW-1:0];
        end else if (rd_r > key_r) begin
          hi_nxt = mid_r - PW'(1);
        end else begin
          lo_nxt = mid_r + PW'(1);
        end
      end
      bas_pkg::OP_FALL_INIT: begin
        lo_nxt = peak_r + PW'(1);
        hi_nxt = n_m1;
      end
      bas_pkg::OP_FALL_UPD: begin
        if (rd_r == key_r) begin
          found_nxt = 1'b1;
          pos_nxt   = mid_r[IW-1:0];
        end else if (rd_r < key_r) begin
          hi_nxt = mid_r - PW'(1);
        end else begin
          lo_nxt = mid_r + PW'(1);
        end
      end
      bas_pkg::OP_MISS: begin
        found_nxt = 1'b0;
        pos_nxt   = '0;
      end
      bas_pkg::OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_pos_nxt   = pos_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= bas_pkg::S_IDLE;
      len_r       <= LW'(1);
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    key_r       <= key_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    peak_r      <= peak_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    found_r     <= found_nxt;
    pos_r       <= pos_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_pos_r, out_found_r};

  `BAS_ASSERT_NEXT(a_search_enters, in_acc && is_search, step_r == bas_pkg::S_ENTRY, "search start lost")
  `BAS_ASSERT_NOW(a_peak_window, step_r == bas_pkg::P_TOP, lo_r <= hi_r, "peak window empty")
  `BAS_ASSERT_NOW(a_hit_in_range, step_r == bas_pkg::S_EMIT && found_r, {1'b0, pos_r} < n_r, "hit beyond length")
  `BAS_ASSERT_NEXT(a_emit_source, !out_valid_r || out_tready, !out_valid_r || $past(step_r == bas_pkg::S_EMIT), "result without emit step")

endmodule

`default_nettype wire

@@ tb/bas_result_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the bitonic array search core: watches the input, output and
// config ports, predicts each search result and compares it. Depends on bas_pkg.
module bas_result_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [79:0] in_tdata,  // index[9:0], element[41:10], search_key[73:42], zeros
  input  wire logic [0:0]  in_tuser,  // action[0]
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata, // found[0], position[10:1], zeros
  input  wire logic        cfg_wr_en,
  input  wire logic [10:0] cfg_wr_data,
  output int               fail_count,
  output int               awaited_count
);

  typedef struct packed {
    logic                      found;
    logic [bas_pkg::IDX_W-1:0] position;
  } search_result_t;

  logic signed [bas_pkg::DATA_W-1:0] elems [bas_pkg::MAX_LENGTH];
  logic [bas_pkg::LEN_W-1:0]         len_reg = bas_pkg::LEN_W'(1);
  search_result_t                    awaited [$];
  search_result_t                    got;
  search_result_t                    want;
  int                                fails = 0;
  int                                depth = 0;

  assign fail_count    = fails;
  assign awaited_count = depth;

  function automatic int locate_top(int n);
    int lo;
    int hi;
    int mid;
    logic signed [bas_pkg::DATA_W-1:0] a;
    logic signed [bas_pkg::DATA_W-1:0] b;
    logic signed [bas_pkg::DATA_W-1:0] c;
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      if (lo == hi) return lo;
      if (hi == lo + 1) return (elems[lo] >= elems[hi]) ? lo : hi;
      mid = lo + (hi - lo) / 2;
      a = elems[mid - 1];
      b = elems[mid];
      c = elems[mid + 1];
      if (a < b && b < c) lo = mid + 1;
      else if (a > b && b > c) hi = mid - 1;
      else return mid;
    end
    return lo;
  endfunction

  // Binary search over [lo, hi]; descending selects the falling half.
  function automatic int scan_half(int lo_in, int hi_in,
                                   logic signed [bas_pkg::DATA_W-1:0] key,
                                   bit descending);
    int lo;
    int hi;
    int mid;
    logic signed [bas_pkg::DATA_W-1:0] v;
    lo = lo_in;
    hi = hi_in;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      v = elems[mid];
      if (v == key) return mid;
      if ((v > key) != descending) hi = mid - 1;
      else lo = mid + 1;
    end
    return -1;
  endfunction

  function automatic search_result_t predict_search(logic signed [bas_pkg::DATA_W-1:0] key);
    search_result_t r;
    int n;
    int peak;
    int pos;
    r = '0;
    n = (len_reg > bas_pkg::MAX_LENGTH) ? bas_pkg::MAX_LENGTH : int'(len_reg);
    if (n == 0) return r;
    peak = locate_top(n);
    pos = scan_half(0, peak, key, 1'b0);
    if (pos < 0) pos = scan_half(peak + 1, n - 1, key, 1'b1);
    if (pos >= 0) begin
      r.found    = 1'b1;
      r.position = pos[bas_pkg::IDX_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      len_reg = bas_pkg::LEN_W'(1);
      awaited.delete();
      depth = 0;
    end else begin
      // results first, so a premature result is never matched to this edge's search
      if (out_tvalid && out_tready) begin
        got.found    = out_tdata[0];
        got.position = out_tdata[10:1];
        if (awaited.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result transaction: found=%0d position=%0d",
                     got.found, got.position);
        end else begin
          want = awaited.pop_front();
          if (got.found !== want.found || got.position !== want.position) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected found=%0d pos=%0d, got found=%0d pos=%0d",
                       want.found, want.position, got.found, got.position);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0]) awaited.push_back(predict_search(in_tdata[73:42]));
        else elems[in_tdata[9:0]] = in_tdata[41:10];
      end
      // a length written at this edge applies from the next transaction on
      if (cfg_wr_en) len_reg = cfg_wr_data;
      depth = awaited.size();
    end
  end

endmodule

@@ tb/tb_bitonic_array_search_core.sv @@
`timescale 1ns / 1ps
// Testbench top for the bitonic array search core: loads bitonic and irregular arrays,
// issues searches and gives the verdict. Depends on bas_pkg, bas_result_checker and the core.
module tb_bitonic_array_search_core;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;
  localparam int   ITEMS      = 1900;
  localparam int   SETTLE     = 128;
  localparam int   IDLE_LIMIT = 4000;

  typedef enum int {FILL_STRICT, FILL_FLAT, FILL_NOISE} fill_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;  // index[9:0], element[41:10], search_key[73:42], zeros
  logic [0:0]  in_tuser = '0;  // action[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;      // found[0], position[10:1], zeros
  logic        cfg_wr_en = 1'b0;
  logic [10:0] cfg_wr_data = '0;

  int          fail_count;
  int          awaited_count;
  int          item_count = 0;
  int          idle_cycles = 0;
  bit          steady = 1'b0;
  logic [31:0] vals [bas_pkg::MAX_LENGTH];

  bitonic_array_search_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  bas_result_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (fail_count),
    .awaited_count(awaited_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(input logic act, input logic [9:0] idx, input logic [31:0] elem,
                           input logic [31:0] key);
    while (!steady && $urandom_range(0, 99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {6'd0, key, elem, idx};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    item_count++;
  endtask

  task automatic load_elem(input int idx, input logic [31:0] v);
    send_item(ACT_LOAD, idx[9:0], v, $urandom);
    vals[idx] = v;
  endtask

  task automatic search_for(input logic [31:0] key);
    send_item(ACT_SEARCH, 10'($urandom_range(0, bas_pkg::MAX_LENGTH - 1)), $urandom, key);
  endtask

  // drain: all results in, then let any trailing load finish
  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (awaited_count != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_length(input int v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[10:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic fill_array(input int nn, input fill_style_t style);
    int          top_at;
    int          i;
    int unsigned step_cap;
    longint      v;
    longint      stride;
    top_at   = $urandom_range(0, nn - 1);
    step_cap = ($urandom_range(0, 9) == 0) ? 32'h7fff_ffff : (32'd1 << $urandom_range(0, 20));
    v = ($urandom_range(0, 9) == 0) ? -64'sd2147483648 : longint'($signed($urandom));
    for (i = 0; i < nn; i++) begin
      if (i > 0) begin
        stride = $urandom_range(0, step_cap);
        if (style == FILL_STRICT && stride == 0) stride = 1;
        if (style == FILL_FLAT && $urandom_range(0, 2) == 0) stride = 0;
        v = (i <= top_at) ? v + stride : v - stride;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
      end
      load_elem(i, (style == FILL_NOISE) ? $urandom : v[31:0]);
    end
  endtask

  task automatic random_search(input int nn);
    int          r;
    int          pick;
    logic [31:0] key;
    r = $urandom_range(0, 99);
    if (nn == 0 || (r >= 75 && r < 85)) begin
      key = $urandom;
    end else begin
      pick = $urandom_range(0, nn - 1);
      if (r >= 90) begin
        load_elem(pick, $urandom);
        pick = $urandom_range(0, nn - 1);
      end
      key = vals[pick];
      if (r >= 60 && r < 75) begin
        key = $urandom_range(0, 1) ? key + 32'd1 : key - 32'd1;
      end else if (r >= 85 && r < 90) begin
        case ($urandom_range(0, 2))
          0: key = 32'h8000_0000;
          1: key = 32'h7fff_ffff;
          default: key = 32'h0;
        endcase
      end
    end
    search_for(key);
  endtask

  initial begin : stimulus
    int          n;
    int          nn;
    int          r;
    int          k;
    bit          big_done;
    fill_style_t style;
    big_done = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // single element at the negative extreme
    load_elem(0, 32'h8000_0000);
    search_for(32'h8000_0000);
    search_for(32'h7fff_ffff);
    // empty array
    quiesce();
    set_length(0);
    search_for(32'h0);
    // two elements: larger one, then a tie
    quiesce();
    set_length(2);
    load_elem(1, 32'h7fff_ffff);
    search_for(32'h7fff_ffff);
    load_elem(1, 32'h8000_0000);
    search_for(32'h8000_0000);
    // flat middle, then a dip that breaks the bitonic shape
    quiesce();
    set_length(5);
    load_elem(0, 32'd1);
    load_elem(1, 32'd3);
    load_elem(2, 32'd3);
    load_elem(3, 32'd3);
    load_elem(4, 32'd1);
    search_for(32'd3);
    search_for(32'd1);
    load_elem(2, -32'sd5);
    search_for(32'd3);
    search_for(32'd1);
    load_elem(bas_pkg::MAX_LENGTH - 1, 32'hffff_ffff);

    item_count = 0;
    while (item_count < ITEMS) begin
      if (!big_done && item_count >= 400) begin
        // full-size array, no idling on either side
        steady = 1'b1;
        quiesce();
        set_length(bas_pkg::MAX_LENGTH);
        fill_array(bas_pkg::MAX_LENGTH, FILL_STRICT);
        repeat (40) random_search(bas_pkg::MAX_LENGTH);
        quiesce();
        set_length(2047);
        repeat (40) random_search(bas_pkg::MAX_LENGTH);
        steady   = 1'b0;
        big_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) n = 0;
        else if (r < 10) n = 1;
        else if (r < 20) n = $urandom_range(2, 3);
        else if (r < 25 && big_done) n = $urandom_range(bas_pkg::MAX_LENGTH, 2047);
        else n = $urandom_range(4, 40);
        nn = (n > bas_pkg::MAX_LENGTH) ? bas_pkg::MAX_LENGTH : n;
        quiesce();
        set_length(n);
        if (nn > 64) begin
          repeat ($urandom_range(0, 8)) load_elem($urandom_range(0, nn - 1), $urandom);
        end else if (nn > 0) begin
          r = $urandom_range(0, 99);
          style = (r < 70) ? FILL_STRICT : (r < 85) ? FILL_FLAT : FILL_NOISE;
          fill_array(nn, style);
        end
        k = $urandom_range(3, 12);
        repeat (k) random_search(nn);
        if ($urandom_range(0, 4) == 0) begin
          load_elem($urandom_range(0, bas_pkg::MAX_LENGTH - 1), $urandom);
        end
      end
    end

    quiesce();
    if (fail_count == 0 && awaited_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
